FILE: hdl/sgb_pkg.sv
// ---------------------------------------------------------------------------
// Selective Gaussian blur package
// Shared constants, pixel layout and the controller/datapath command types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sgb_pkg;

  localparam int DEF_RADIUS    = 5;
  localparam int DEF_MAX_WIDTH = 2048;
  localparam int CH_W          = 16;
  localparam int CFG_AW        = 4;
  localparam int CFG_DW        = 32;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [1:0] REG_SRC_WIDTH    = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_GUIDE_THRESH = 2'd2;

  localparam logic [11:0] RST_SRC_WIDTH    = 12'd2048;
  localparam logic [15:0] RST_SRC_HEIGHT   = 16'd1;
  localparam logic [15:0] RST_GUIDE_THRESH = 16'd13107;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] g_red;
    logic [CH_W-1:0] g_green;
    logic [CH_W-1:0] g_blue;
  } pixel_t;

  localparam int PIX_W = $bits(pixel_t);

  typedef struct packed {
    logic load;
    logic line_rd;
    logic new_wr;
    logic center_rd;
    logic center_lat;
    logic tap_rd;
    logic div_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic line_last;
    logic emit;
    logic tap_last;
    logic pipe_empty;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: hdl/sgb_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sgb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/sgb_ctrl.sv
// ---------------------------------------------------------------------------
// Selective Gaussian blur controller
// Sequences line fetch, window update, tap accumulation, division and output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sgb_ctrl import sgb_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  output cmd_t         cmd,
  input  wire status_t st
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LREAD  = 4'd1;
  localparam logic [3:0] S_LLAST  = 4'd2;
  localparam logic [3:0] S_LNEW   = 4'd3;
  localparam logic [3:0] S_CRD    = 4'd4;
  localparam logic [3:0] S_CLAT   = 4'd5;
  localparam logic [3:0] S_TAPS   = 4'd6;
  localparam logic [3:0] S_DRAIN  = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_LREAD;
        end
      end
      S_LREAD: begin
        cmd.line_rd = 1'b1;
        if (st.line_last) begin
          state_next = S_LLAST;
        end
      end
      S_LLAST: begin
        state_next = S_LNEW;
      end
      S_LNEW: begin
        cmd.new_wr = 1'b1;
        state_next = st.emit ? S_CRD : S_IDLE;
      end
      S_CRD: begin
        cmd.center_rd = 1'b1;
        state_next    = S_CLAT;
      end
      S_CLAT: begin
        cmd.center_lat = 1'b1;
        state_next     = S_TAPS;
      end
      S_TAPS: begin
        cmd.tap_rd = 1'b1;
        if (st.tap_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (st.pipe_empty) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (st.div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_div_after_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> st.pipe_empty)
    else $error("division started with taps still in flight");

  a_load_to_fetch: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_LREAD))
    else $error("accepted beat did not start the line fetch");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.out_free)
    else $error("result loaded over a pending output beat");

  a_taps_follow_center: assert property (@(posedge clk) disable iff (rst)
    cmd.center_rd |=> cmd.center_lat)
    else $error("center read not followed by its latch");

endmodule

`default_nettype wire

FILE: hdl/sgb_dp.sv
// ---------------------------------------------------------------------------
// Selective Gaussian blur datapath
// Position counters, line store, window store, tap pipeline, divider, output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sgb_dp import sgb_pkg::*; #(
  parameter int RADIUS    = DEF_RADIUS,
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cmd_t             cmd,
  output status_t               st,
  input  wire logic [11:0]      source_width,
  input  wire logic [15:0]      source_height,
  input  wire logic [15:0]      guide_thresh,
  input  wire pixel_t           in_pix,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [CH_W-1:0]       out_red,
  output logic [CH_W-1:0]       out_green,
  output logic [CH_W-1:0]       out_blue,
  output logic [CH_W-1:0]       out_alpha,
  output logic                  frame_end
);

  localparam int SPAN      = 2 * RADIUS + 1;
  localparam int BAND      = 2 * RADIUS;
  localparam int MAXD2     = 2 * RADIUS * RADIUS;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int CW        = COL_W + 1;
  localparam int ROW_W     = $clog2(SPAN);
  localparam int BAND_W    = $clog2(BAND);
  localparam int LS_DEPTH  = BAND * MAX_WIDTH;
  localparam int LS_AW     = $clog2(LS_DEPTH);
  localparam int WIN_DEPTH = SPAN * (1 << ROW_W);
  localparam int WIN_AW    = $clog2(WIN_DEPTH);
  localparam int GW        = 17;
  localparam int WT_W      = GW + CH_W;
  localparam int PW        = WT_W + CH_W;
  localparam int WS_W      = WT_W + $clog2(SPAN * SPAN);
  localparam int VS_W      = WS_W + CH_W;
  localparam int D2_W      = $clog2(MAXD2 + 1);
  localparam int QC_W      = $clog2(CH_W + 1);

  typedef logic [MAXD2:0][GW-1:0] rom_t;

  // Gaussian weights exp(-d2 / (2*RADIUS)) in Q1.16, built at elaboration.
  function automatic rom_t gauss_rom();
    rom_t         r;
    logic [63:0]  term;
    logic [63:0]  base;
    logic [63:0]  e;
    logic [127:0] p;
    term = 64'h1_0000_0000;
    base = term;
    e    = term;
    term = term / (BAND * 1);  base = base - term;
    term = term / (BAND * 2);  base = base + term;
    term = term / (BAND * 3);  base = base - term;
    term = term / (BAND * 4);  base = base + term;
    term = term / (BAND * 5);  base = base - term;
    term = term / (BAND * 6);  base = base + term;
    term = term / (BAND * 7);  base = base - term;
    term = term / (BAND * 8);  base = base + term;
    term = term / (BAND * 9);  base = base - term;
    term = term / (BAND * 10); base = base + term;
    term = term / (BAND * 11); base = base - term;
    term = term / (BAND * 12); base = base + term;
    for (int d = 0; d <= MAXD2; d++) begin
      r[d] = GW'((e + 64'h8000) >> 16);
      p    = 128'(e) * 128'(base);
      e    = 64'((p + 128'h8000_0000) >> 32);
    end
    return r;
  endfunction

  localparam rom_t ROM = gauss_rom();

  function automatic logic [CH_W-1:0] color_of(pixel_t p, int c);
    logic [CH_W-1:0] v;
    case (c)
      0:       v = p.red;
      1:       v = p.green;
      default: v = p.blue;
    endcase
    return v;
  endfunction

  function automatic logic [CH_W-1:0] guide_of(pixel_t p, int c);
    logic [CH_W-1:0] v;
    case (c)
      0:       v = p.g_red;
      1:       v = p.g_green;
      default: v = p.g_blue;
    endcase
    return v;
  endfunction

  // ---- position tracking --------------------------------------------------
  logic [COL_W-1:0]  column_count;
  logic [15:0]       row_count;
  logic [BAND_W-1:0] row_slot;
  logic [ROW_W-1:0]  wptr;

  logic [31:0]       w32;
  logic [CW-1:0]     w;
  logic [16:0]       h17;
  logic [COL_W-1:0]  col_eff;
  logic              row_end;
  logic              fend_now;
  logic              emit_now;
  logic [BAND_W-1:0] row_slot_inc;

  always_comb begin
    if (source_width == 12'd0) begin
      w32 = 32'd1;
    end else if ({20'd0, source_width} > 32'(MAX_WIDTH)) begin
      w32 = 32'(MAX_WIDTH);
    end else begin
      w32 = {20'd0, source_width};
    end
    w        = CW'(w32);
    h17      = (source_height == 16'd0) ? 17'd1 : {1'b0, source_height};
    col_eff  = ({1'b0, column_count} >= w) ? COL_W'(w - CW'(1)) : column_count;
    row_end  = ({1'b0, col_eff} + CW'(1)) >= w;
    fend_now = row_end && (({1'b0, row_count} + 17'd1) >= h17);
    emit_now = (col_eff >= COL_W'(BAND)) && (row_count >= 16'(BAND));
    row_slot_inc = (row_slot == BAND_W'(BAND - 1)) ? '0 : row_slot + BAND_W'(1);
  end

  logic [COL_W-1:0]  cur_col;
  logic [BAND_W-1:0] cur_slot;
  pixel_t            cur_pix;
  logic              emit_r;
  logic              fend_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      row_slot     <= '0;
      wptr         <= '0;
    end else if (cmd.load) begin
      wptr <= (wptr == ROW_W'(SPAN - 1)) ? '0 : wptr + ROW_W'(1);
      if (fend_now) begin
        column_count <= '0;
        row_count    <= '0;
        row_slot     <= '0;
      end else if (row_end) begin
        column_count <= '0;
        row_count    <= row_count + 16'd1;
        row_slot     <= row_slot_inc;
      end else begin
        column_count <= col_eff + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_col  <= col_eff;
      cur_slot <= row_slot;
      cur_pix  <= in_pix;
      emit_r   <= emit_now;
      fend_r   <= fend_now;
    end
  end

  // ---- line store fetch into the newest window column ----------------------
  logic [BAND_W-1:0] rd_k;
  logic [BAND_W-1:0] rd_slot;
  logic [BAND_W-1:0] rd_pk;
  logic              rd_pend;
  logic [LS_AW-1:0]  ls_raddr;
  logic [LS_AW-1:0]  ls_waddr;
  logic [PIX_W-1:0]  ls_rdata;

  assign ls_raddr = LS_AW'(rd_slot) * LS_AW'(MAX_WIDTH) + LS_AW'(cur_col);
  assign ls_waddr = LS_AW'(cur_slot) * LS_AW'(MAX_WIDTH) + LS_AW'(cur_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.line_rd;
    end
  end

  always_ff @(posedge clk) begin
    rd_pk <= rd_k;
    if (cmd.load) begin
      rd_k    <= '0;
      rd_slot <= row_slot;
    end else if (cmd.line_rd) begin
      rd_k    <= rd_k + BAND_W'(1);
      rd_slot <= (rd_slot == BAND_W'(BAND - 1)) ? '0 : rd_slot + BAND_W'(1);
    end
  end

  sgb_ram #(.WIDTH(PIX_W), .DEPTH(LS_DEPTH)) u_line_store (
    .clk   (clk),
    .we    (cmd.new_wr),
    .waddr (ls_waddr),
    .wdata (cur_pix),
    .raddr (ls_raddr),
    .rdata (ls_rdata)
  );

  // ---- window store: SPAN column slots of SPAN rows ------------------------
  logic [ROW_W-1:0]  tx;
  logic [ROW_W-1:0]  ty;
  logic [ROW_W-1:0]  tslot;
  logic [ROW_W:0]    csum;
  logic [ROW_W-1:0]  cslot;
  logic [ROW_W-1:0]  first_slot;
  logic              win_we;
  logic [WIN_AW-1:0] win_waddr;
  logic [PIX_W-1:0]  win_wdata;
  logic [WIN_AW-1:0] win_raddr;
  pixel_t            win_rdata;

  always_comb begin
    csum       = (ROW_W + 1)'(wptr) + (ROW_W + 1)'(RADIUS + 1);
    cslot      = (csum >= (ROW_W + 1)'(SPAN)) ? ROW_W'(csum - (ROW_W + 1)'(SPAN))
                                               : ROW_W'(csum);
    first_slot = (wptr == ROW_W'(SPAN - 1)) ? '0 : wptr + ROW_W'(1);
    win_we     = rd_pend || cmd.new_wr;
    win_waddr  = cmd.new_wr ? WIN_AW'({wptr, ROW_W'(BAND)}) : WIN_AW'({wptr, ROW_W'(rd_pk)});
    win_wdata  = cmd.new_wr ? cur_pix : ls_rdata;
    win_raddr  = cmd.center_rd ? WIN_AW'({cslot, ROW_W'(RADIUS)}) : WIN_AW'({tslot, ty});
  end

  sgb_ram #(.WIDTH(PIX_W), .DEPTH(WIN_DEPTH)) u_window (
    .clk   (clk),
    .we    (win_we),
    .waddr (win_waddr),
    .wdata (win_wdata),
    .raddr (win_raddr),
    .rdata (win_rdata)
  );

  // ---- tap pipeline ---------------------------------------------------------
  pixel_t           center;
  logic [ROW_W-1:0] ox;
  logic [ROW_W-1:0] oy;
  logic [D2_W-1:0]  d2;
  logic [D2_W-1:0]  d2_1;
  logic             v1;
  logic             v2;
  logic             v3;
  logic [WT_W-1:0]  wt2;
  logic [2:0]       m2;
  logic [CH_W-1:0]  val2 [3];
  logic [PW-1:0]    p3   [3];
  logic [WT_W-1:0]  wm3  [3];
  logic [WS_W-1:0]  ws   [3];
  logic [VS_W-1:0]  vs   [3];
  logic [CH_W-1:0]  gdiff [3];

  always_comb begin
    ox = (tx >= ROW_W'(RADIUS)) ? tx - ROW_W'(RADIUS) : ROW_W'(RADIUS) - tx;
    oy = (ty >= ROW_W'(RADIUS)) ? ty - ROW_W'(RADIUS) : ROW_W'(RADIUS) - ty;
    d2 = D2_W'((2 * ROW_W)'(ox) * (2 * ROW_W)'(ox) + (2 * ROW_W)'(oy) * (2 * ROW_W)'(oy));
    for (int c = 0; c < 3; c++) begin
      gdiff[c] = (guide_of(win_rdata, c) >= guide_of(center, c))
               ? guide_of(win_rdata, c) - guide_of(center, c)
               : guide_of(center, c) - guide_of(win_rdata, c);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.center_lat) begin
      center <= win_rdata;
      tx     <= '0;
      ty     <= '0;
      tslot  <= first_slot;
    end else if (cmd.tap_rd) begin
      if (ty == ROW_W'(SPAN - 1)) begin
        ty    <= '0;
        tx    <= tx + ROW_W'(1);
        tslot <= (tslot == ROW_W'(SPAN - 1)) ? '0 : tslot + ROW_W'(1);
      end else begin
        ty <= ty + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.tap_rd;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    d2_1 <= d2;
    wt2  <= WT_W'(ROM[d2_1]) * WT_W'(win_rdata.alpha);
    for (int c = 0; c < 3; c++) begin
      m2[c]   <= (gdiff[c] <= guide_thresh);
      val2[c] <= color_of(win_rdata, c);
      p3[c]   <= m2[c] ? PW'(wt2) * PW'(val2[c]) : '0;
      wm3[c]  <= m2[c] ? wt2 : '0;
    end
    if (cmd.center_lat) begin
      for (int c = 0; c < 3; c++) begin
        ws[c] <= '0;
        vs[c] <= '0;
      end
    end else if (v3) begin
      for (int c = 0; c < 3; c++) begin
        ws[c] <= ws[c] + WS_W'(wm3[c]);
        vs[c] <= vs[c] + VS_W'(p3[c]);
      end
    end
  end

  // ---- rounded division, one quotient bit per cycle per channel -------------
  logic [QC_W-1:0] dcnt;
  logic [WS_W-1:0] rem  [3];
  logic [CH_W-1:0] nlo  [3];
  logic [CH_W-1:0] quo  [3];
  logic [VS_W-1:0] num  [3];
  logic [WS_W:0]   trial [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num[c]   = vs[c] + VS_W'(ws[c] >> 1);
      trial[c] = {rem[c], nlo[c][CH_W-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.div_start) begin
      dcnt <= QC_W'(CH_W);
    end else if (dcnt != '0) begin
      dcnt <= dcnt - QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (cmd.div_start) begin
        // The quotient fits in one channel, so the upper part is already below W.
        rem[c] <= WS_W'(num[c] >> CH_W);
        nlo[c] <= num[c][CH_W-1:0];
        quo[c] <= '0;
      end else if (dcnt != '0) begin
        nlo[c] <= nlo[c] << 1;
        if (trial[c] >= {1'b0, ws[c]}) begin
          rem[c] <= WS_W'(trial[c] - {1'b0, ws[c]});
          quo[c] <= {quo[c][CH_W-2:0], 1'b1};
        end else begin
          rem[c] <= trial[c][WS_W-1:0];
          quo[c] <= {quo[c][CH_W-2:0], 1'b0};
        end
      end
    end
  end

  // ---- output register ------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_red   <= (ws[0] == '0) ? center.red   : quo[0];
      out_green <= (ws[1] == '0) ? center.green : quo[1];
      out_blue  <= (ws[2] == '0) ? center.blue  : quo[2];
      out_alpha <= center.alpha;
      frame_end <= fend_r;
    end
  end

  always_comb begin
    st.line_last  = (rd_k == BAND_W'(BAND - 1));
    st.emit       = emit_r;
    st.tap_last   = (tx == ROW_W'(SPAN - 1)) && (ty == ROW_W'(SPAN - 1));
    st.pipe_empty = !v1 && !v2 && !v3;
    st.div_done   = (dcnt == '0);
    st.out_free   = !out_valid;
  end

endmodule

`default_nettype wire

FILE: hdl/selective_gaussian_blur.sv
// ---------------------------------------------------------------------------
// Selective Gaussian blur
// Edge-preserving Gaussian filter over a streamed, border-extended raster.
// ---------------------------------------------------------------------------
// Pixels enter in raster order on the input channel (in_valid / in_stall),
// each beat carrying the RGBA source and the RGB guide; send the source
// color again as guide when there is none. Every beat whose column and row
// are both at least 2*RADIUS completes a window and yields one beat on the
// output channel (out_valid / out_stall); other beats yield nothing.
// Each input beat occupies the block while its 2*RADIUS line store rows
// are fetched into the newest window column and the beat is written; a beat
// that yields a result then has the window taps read one per cycle from the
// window store and fed through a single weight/accumulate pipeline,
// followed by a bit-serial division for the three channels.
// The next beat is accepted while a result still waits in the output
// register; a stalled receiver holds off the input only once a second
// result is ready before the first has left.
// Reset clears the position counters and the output valid flag; line and
// window contents are undefined until written. Set geometry and threshold
// through the APB port between beats; the block does not enforce this.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module selective_gaussian_blur import sgb_pkg::*; #(
  parameter int RADIUS    = DEF_RADIUS,
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CH_W-1:0]   src_red,
  input  wire logic [CH_W-1:0]   src_green,
  input  wire logic [CH_W-1:0]   src_blue,
  input  wire logic [CH_W-1:0]   src_alpha,
  input  wire logic [CH_W-1:0]   guide_red,
  input  wire logic [CH_W-1:0]   guide_green,
  input  wire logic [CH_W-1:0]   guide_blue,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [CH_W-1:0]        out_red,
  output logic [CH_W-1:0]        out_green,
  output logic [CH_W-1:0]        out_blue,
  output logic [CH_W-1:0]        out_alpha,
  output logic                   frame_end
);

  logic [11:0] source_width;
  logic [15:0] source_height;
  logic [15:0] guide_thresh;
  logic        cfg_wr;
  cmd_t        cmd;
  status_t     st;
  pixel_t      in_pix;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= RST_SRC_WIDTH;
      source_height <= RST_SRC_HEIGHT;
      guide_thresh  <= RST_GUIDE_THRESH;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SRC_WIDTH:    source_width  <= pwdata[11:0];
        REG_SRC_HEIGHT:   source_height <= pwdata[15:0];
        REG_GUIDE_THRESH: guide_thresh  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SRC_WIDTH:    prdata = {20'd0, source_width};
      REG_SRC_HEIGHT:   prdata = {16'd0, source_height};
      REG_GUIDE_THRESH: prdata = {16'd0, guide_thresh};
      default:          prdata = '0;
    endcase
  end

  assign in_pix = '{red: src_red, green: src_green, blue: src_blue, alpha: src_alpha,
                    g_red: guide_red, g_green: guide_green, g_blue: guide_blue};

  sgb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .st       (st)
  );

  sgb_dp #(.RADIUS(RADIUS), .MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .source_width  (source_width),
    .source_height (source_height),
    .guide_thresh  (guide_thresh),
    .in_pix        (in_pix),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha     (out_alpha),
    .frame_end     (frame_end)
  );

endmodule

`default_nettype wire
